@@ hw/rtl/tash_pkg.sv @@
// Package for the three-axis stepper homing block.
// Holds the word types, the configuration layout, register indexes and phase codes.
// Depends on nothing.
`default_nettype none

package tash_pkg;

    localparam int NUM_AXES_DEF    = 3;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int PERIOD_W  = 16;
    localparam int FACTOR_W  = 8;
    localparam int BACKOFF_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [PERIOD_W-1:0]  FAST_PERIOD_RST = PERIOD_W'(100);
    localparam logic [FACTOR_W-1:0]  SLOW_FACTOR_RST = FACTOR_W'(10);
    localparam logic [BACKOFF_W-1:0] BACKOFF_RST     = BACKOFF_W'(800);

    localparam logic [CFG_IDX_W-1:0] CFG_FAST_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_FACTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF     = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_FAST    = 3'd1,
        PH_BACKOFF = 3'd2,
        PH_SLOW    = 3'd3,
        PH_DONE    = 3'd4
    } t_phase;

    typedef struct packed {
        logic start_req;
        logic sensor_one;
        logic sensor_two;
        logic sensor_three;
    } t_in_word;

    typedef struct packed {
        logic       step_one;
        logic       step_two;
        logic       step_three;
        logic       dir_forward;
        logic       drive_enable;
        logic [2:0] phase;
    } t_out_word;

    typedef struct packed {
        logic [PERIOD_W-1:0]  fast_period_ticks;
        logic [FACTOR_W-1:0]  slow_factor;
        logic [BACKOFF_W-1:0] backoff_toggles;
    } t_cfg;

endpackage

`default_nettype wire

@@ hw/rtl/tash_cfg.sv @@
// Configuration registers of the homing block.
// Uses tash_pkg for the register layout and indexes.
`default_nettype none

module tash_cfg
    import tash_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fast_period_ticks <= FAST_PERIOD_RST;
            r_cfg.slow_factor       <= SLOW_FACTOR_RST;
            r_cfg.backoff_toggles   <= BACKOFF_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FAST_PERIOD: r_cfg.fast_period_ticks <= i_cfg_data[PERIOD_W-1:0];
                CFG_SLOW_FACTOR: r_cfg.slow_factor       <= i_cfg_data[FACTOR_W-1:0];
                CFG_BACKOFF:     r_cfg.backoff_toggles   <= i_cfg_data[BACKOFF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ hw/rtl/tash_seq.sv @@
// Homing sequencer: phase state, tick and period counters, axis and step state.
// Uses tash_pkg for word types, configuration layout and phase codes.
`default_nettype none

module tash_seq
    import tash_pkg::*;
#(
    parameter int NUM_AXES    = NUM_AXES_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_advance,
    input  wire t_in_word i_word,
    input  wire t_cfg     i_cfg,
    output t_out_word     o_result
);

    localparam int CW   = COUNT_WIDTH;
    localparam int N    = NUM_AXES;
    localparam int CMPW = (CW > BACKOFF_W) ? CW : BACKOFF_W;

    t_phase              r_phase,   n_phase;
    logic [CW-1:0]       r_tick,    n_tick;
    logic [FACTOR_W-1:0] r_slow,    n_slow;
    logic [CW-1:0]       r_backoff, n_backoff;
    logic [N-1:0]        r_active,  n_active;
    logic [N-1:0]        r_steps,   n_steps;
    logic                r_dir,     n_dir;
    logic                r_en,      n_en;

    logic                fast_hit;
    logic [CW-1:0]       tick_step;
    logic                slow_hit;
    logic [FACTOR_W-1:0] slow_inc;
    logic [FACTOR_W-1:0] slow_after;
    logic [FACTOR_W-1:0] factor;
    logic                slow_bound;
    logic                back_hit;
    logic [CW-1:0]       back_step;
    logic [7:0]          trig_all;
    logic [N-1:0]        trig;
    logic [N-1:0]        active_after;
    logic [7:0]          steps_ext;

    function automatic logic [CW-1:0] f_bump(input logic [CW-1:0] cnt);
        logic [CW-1:0] c;
        c = cnt + 1'b1;
        if (c == '0) begin
            c = '1;
        end
        return c;
    endfunction

    function automatic logic f_reached(input logic [CW-1:0] cnt,
                                       input logic [15:0] target);
        logic [CW-1:0]   c;
        logic [CMPW-1:0] ce;
        logic [CMPW-1:0] te;
        c  = f_bump(cnt);
        ce = CMPW'(c);
        te = (target == '0) ? CMPW'(1) : CMPW'(target);
        return (ce >= te) || (c == '1);
    endfunction

    always_comb begin
        fast_hit   = f_reached(r_tick, i_cfg.fast_period_ticks);
        tick_step  = fast_hit ? '0 : f_bump(r_tick);
        factor     = (i_cfg.slow_factor == '0) ? FACTOR_W'(1) : i_cfg.slow_factor;
        slow_inc   = r_slow + 1'b1;
        slow_hit   = slow_inc >= factor;
        slow_bound = fast_hit && slow_hit;
        slow_after = fast_hit ? (slow_hit ? '0 : slow_inc) : r_slow;
        back_hit   = f_reached(r_backoff, i_cfg.backoff_toggles);
        back_step  = back_hit ? '0 : f_bump(r_backoff);

        trig_all     = {5'b11111, ~i_word.sensor_three, ~i_word.sensor_two,
                        ~i_word.sensor_one};
        trig         = trig_all[N-1:0];
        active_after = r_active & ~trig;
    end

    always_comb begin
        n_phase   = r_phase;
        n_tick    = r_tick;
        n_slow    = r_slow;
        n_backoff = r_backoff;
        n_active  = r_active;
        n_steps   = r_steps;
        n_dir     = r_dir;
        n_en      = r_en;
        priority if (i_word.start_req) begin
            n_phase   = PH_FAST;
            n_en      = 1'b1;
            n_dir     = 1'b0;
            n_tick    = '0;
            n_slow    = '0;
            n_backoff = '0;
            n_active  = '1;
        end else begin
            unique case (r_phase)
                PH_FAST: begin
                    n_tick = tick_step;
                    if (fast_hit) begin
                        n_active = active_after;
                        n_steps  = r_steps ^ active_after;
                        if (active_after == '0) begin
                            n_phase   = PH_BACKOFF;
                            n_dir     = 1'b1;
                            n_tick    = '0;
                            n_slow    = '0;
                            n_backoff = '0;
                        end
                    end
                end
                PH_BACKOFF: begin
                    n_tick = tick_step;
                    n_slow = slow_after;
                    if (slow_bound) begin
                        n_steps   = ~r_steps;
                        n_backoff = back_step;
                        if (back_hit) begin
                            n_phase  = PH_SLOW;
                            n_dir    = 1'b0;
                            n_tick   = '0;
                            n_slow   = '0;
                            n_active = '1;
                        end
                    end
                end
                PH_SLOW: begin
                    n_tick = tick_step;
                    n_slow = slow_after;
                    if (slow_bound) begin
                        n_active = active_after;
                        n_steps  = r_steps ^ active_after;
                        if (active_after == '0) begin
                            n_phase = PH_DONE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_tick    <= '0;
            r_slow    <= '0;
            r_backoff <= '0;
            r_active  <= '1;
            r_steps   <= '0;
            r_dir     <= 1'b0;
            r_en      <= 1'b0;
        end else if (i_advance) begin
            r_phase   <= n_phase;
            r_tick    <= n_tick;
            r_slow    <= n_slow;
            r_backoff <= n_backoff;
            r_active  <= n_active;
            r_steps   <= n_steps;
            r_dir     <= n_dir;
            r_en      <= n_en;
        end
    end

    always_comb begin
        steps_ext             = 8'(n_steps);
        o_result.step_one     = steps_ext[0];
        o_result.step_two     = steps_ext[1];
        o_result.step_three   = steps_ext[2];
        o_result.dir_forward  = n_dir;
        o_result.drive_enable = n_en;
        o_result.phase        = n_phase;
    end

endmodule

`default_nettype wire

@@ hw/rtl/three_axis_stepper_homing.sv @@
// Homing sequencer for three stepper axes: each input word is one base tick and gives one
// result word with the step, direction and enable levels and the phase after that tick.
// The block takes one word per clock unless o_stall is high; as a word leaves the input
// register, its result enters the result register and the sequencer state advances once
// per word. Configuration must be written through the plain write port only while no
// word is in flight; the block does not enforce it. Uses tash_pkg, tash_cfg and tash_seq.
`default_nettype none

module three_axis_stepper_homing
    import tash_pkg::*;
#(
    parameter int NUM_AXES    = NUM_AXES_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire t_in_word              i_data,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output t_out_word                  o_data,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      cfg;
    t_out_word result;
    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    logic      out_free;
    logic      advance;
    logic      accept_in;

    tash_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    tash_seq #(
        .NUM_AXES    (NUM_AXES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_word    (r_in_word),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    assign out_free  = !r_out_valid || !i_stall;
    assign advance   = r_in_valid && out_free;
    assign o_stall   = r_in_valid && !out_free;
    assign accept_in = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept_in) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_in_word <= i_data;
        end
        if (advance) begin
            r_out_word <= result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_word;

    a_enable_when_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.phase != PH_IDLE) |-> o_data.drive_enable)
        else $error("drivers disabled outside idle");

    a_dir_backoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.dir_forward == (o_data.phase == PH_BACKOFF)))
        else $error("direction does not match phase");

    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_word))
        else $error("input word lost while result register full");

endmodule

`default_nettype wire

@@ bench/three_axis_stepper_homing_checker.sv @@
// Checker for the three-axis stepper homing block: watches the input, result and register ports,
// keeps its own model of the homing sequencer and compares every result word field by field.
// Depends on tash_pkg for the word types, register indexes, reset values and phase codes.
`timescale 1ns / 100ps

module three_axis_stepper_homing_checker
    import tash_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_word              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_word             i_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_failures,
    output int                    o_pending,
    output int                    o_checked
);

    logic [PERIOD_W-1:0]  fast_period;
    logic [FACTOR_W-1:0]  slow_factor;
    logic [BACKOFF_W-1:0] backoff_toggles;

    t_phase      phase;
    logic [15:0] tick_cnt;
    logic [7:0]  slow_cnt;
    logic [15:0] backoff_cnt;
    logic [2:0]  active;
    logic [2:0]  levels;
    logic        dir_fwd;
    logic        enabled;

    t_out_word   due_words[$];
    int          fail_count;
    int          checked_count;

    // A counter that reaches its target, or saturates, marks a boundary and restarts from zero.
    function automatic bit count_hit(input logic [15:0] cnt, input logic [15:0] target,
                                     output logic [15:0] nxt);
        logic [15:0] lim;
        logic [15:0] c;
        lim = (target == 16'd0) ? 16'd1 : target;
        c = cnt + 16'd1;
        if (c == 16'd0) c = 16'hFFFF;
        if (c >= lim || c == 16'hFFFF) begin
            nxt = '0;
            return 1'b1;
        end
        nxt = c;
        return 1'b0;
    endfunction

    task automatic slow_tick(output bit hit);
        logic [7:0] lim;
        lim = (slow_factor == 8'd0) ? 8'd1 : slow_factor;
        hit = 1'b0;
        if (count_hit(tick_cnt, fast_period, tick_cnt)) begin
            slow_cnt = slow_cnt + 8'd1;
            if (slow_cnt >= lim) begin
                slow_cnt = '0;
                hit = 1'b1;
            end
        end
    endtask

    task automatic approach_step(input t_in_word w);
        active = active & {w.sensor_three, w.sensor_two, w.sensor_one};
        levels = levels ^ active;
    endtask

    task automatic advance_homing(input t_in_word w);
        bit hit;
        if (w.start_req) begin
            phase = PH_FAST;
            enabled = 1'b1;
            dir_fwd = 1'b0;
            tick_cnt = '0;
            slow_cnt = '0;
            backoff_cnt = '0;
            active = '1;
        end else if (phase == PH_FAST) begin
            if (count_hit(tick_cnt, fast_period, tick_cnt)) begin
                approach_step(w);
                if (active == '0) begin
                    phase = PH_BACKOFF;
                    dir_fwd = 1'b1;
                    tick_cnt = '0;
                    slow_cnt = '0;
                    backoff_cnt = '0;
                end
            end
        end else if (phase == PH_BACKOFF) begin
            slow_tick(hit);
            if (hit) begin
                levels = ~levels;
                if (count_hit(backoff_cnt, backoff_toggles, backoff_cnt)) begin
                    phase = PH_SLOW;
                    dir_fwd = 1'b0;
                    tick_cnt = '0;
                    slow_cnt = '0;
                    active = '1;
                end
            end
        end else if (phase == PH_SLOW) begin
            slow_tick(hit);
            if (hit) begin
                approach_step(w);
                if (active == '0) phase = PH_DONE;
            end
        end
    endtask

    task automatic field_mismatch(input string name, input int unsigned want,
                                  input int unsigned got);
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        t_out_word got;
        bit        bad;
        if (!i_rst_n) begin
            fast_period = FAST_PERIOD_RST;
            slow_factor = SLOW_FACTOR_RST;
            backoff_toggles = BACKOFF_RST;
            phase = PH_IDLE;
            tick_cnt = '0;
            slow_cnt = '0;
            backoff_cnt = '0;
            active = '1;
            levels = '0;
            dir_fwd = 1'b0;
            enabled = 1'b0;
            due_words.delete();
            fail_count = 0;
            checked_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FAST_PERIOD: fast_period = i_cfg_data[PERIOD_W-1:0];
                    CFG_SLOW_FACTOR: slow_factor = i_cfg_data[FACTOR_W-1:0];
                    CFG_BACKOFF:     backoff_toggles = i_cfg_data[BACKOFF_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                advance_homing(i_in_data);
                want.step_one = levels[0];
                want.step_two = levels[1];
                want.step_three = levels[2];
                want.dir_forward = dir_fwd;
                want.drive_enable = enabled;
                want.phase = phase;
                due_words.push_back(want);
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (due_words.size() == 0) begin
                    $display("%0t ns: result word with nothing expected, actual %0h",
                             $time, got);
                    fail_count++;
                end else begin
                    want = due_words.pop_front();
                    bad = 1'b0;
                    if (got.step_one !== want.step_one) begin
                        field_mismatch("step_one", want.step_one, got.step_one);
                        bad = 1'b1;
                    end
                    if (got.step_two !== want.step_two) begin
                        field_mismatch("step_two", want.step_two, got.step_two);
                        bad = 1'b1;
                    end
                    if (got.step_three !== want.step_three) begin
                        field_mismatch("step_three", want.step_three, got.step_three);
                        bad = 1'b1;
                    end
                    if (got.dir_forward !== want.dir_forward) begin
                        field_mismatch("dir_forward", want.dir_forward, got.dir_forward);
                        bad = 1'b1;
                    end
                    if (got.drive_enable !== want.drive_enable) begin
                        field_mismatch("drive_enable", want.drive_enable, got.drive_enable);
                        bad = 1'b1;
                    end
                    if (got.phase !== want.phase) begin
                        field_mismatch("phase", want.phase, got.phase);
                        bad = 1'b1;
                    end
                    if (bad) fail_count++;
                    checked_count++;
                end
            end
        end
        o_failures <= fail_count;
        o_pending <= due_words.size();
        o_checked <= checked_count;
    end

endmodule

@@ bench/three_axis_stepper_homing_test.sv @@
// Top of the testbench for the three-axis stepper homing block: drives clock, reset, register
// writes and input words, stalls the result side, and gives the verdict.
// Depends on tash_pkg, three_axis_stepper_homing and three_axis_stepper_homing_checker.
`timescale 1ns / 100ps

module three_axis_stepper_homing_test;
    import tash_pkg::*;

    localparam int HOLD_CYCLES = 64;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    t_in_word              i_data;
    logic                  o_valid;
    logic                  i_stall;
    t_out_word             o_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int failures;
    int pending_words;
    int checked_words;
    int words_sent = 0;
    int settings_used = 0;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;

    // Bits of each directed word, from the top: start_req, sensor_one, sensor_two, sensor_three.
    logic [3:0] opening_words[3] = '{4'b0111, 4'b1111, 4'b0111};
    logic [3:0] directed_words[18] = '{
        4'b0111, 4'b1111, 4'b0011, 4'b0111, 4'b0101, 4'b0110,
        4'b0000, 4'b0111, 4'b1111, 4'b0000, 4'b1000, 4'b0000,
        4'b0000, 4'b0011, 4'b0000, 4'b0111, 4'b1000, 4'b0111
    };

    three_axis_stepper_homing dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    three_axis_stepper_homing_checker homing_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_in_data   (i_data),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_out_data  (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_failures  (failures),
        .o_pending   (pending_words),
        .o_checked   (checked_words)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic send_word(input t_in_word w);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        words_sent++;
    endtask

    task automatic drain_results;
        int waited;
        i_valid <= 1'b0;
        @(posedge i_clk);
        waited = 0;
        while (pending_words != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_settings(input logic [PERIOD_W-1:0] fast,
                                  input logic [FACTOR_W-1:0] slow,
                                  input logic [BACKOFF_W-1:0] backoff);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_FAST_PERIOD;
        i_cfg_data <= CFG_DATA_W'(fast);
        @(posedge i_clk);
        i_cfg_idx <= CFG_SLOW_FACTOR;
        i_cfg_data <= CFG_DATA_W'(slow);
        @(posedge i_clk);
        i_cfg_idx <= CFG_BACKOFF;
        i_cfg_data <= CFG_DATA_W'(backoff);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Mostly whole homing runs that open with a start and see sensors fall at random;
    // now and then a noisy run full of restarts.
    task automatic random_runs(input int budget);
        t_in_word w;
        int       len;
        int       odds;
        int       restart_odds;
        bit       noisy;
        for (int done_words = 0; done_words < budget; done_words += len) begin
            len = $urandom_range(20, 120);
            if (len > budget - done_words) len = budget - done_words;
            noisy = ($urandom_range(0, 9) == 0);
            if (noisy) begin
                odds = 2;
                restart_odds = 2;
            end else begin
                case ($urandom_range(0, 2))
                    0: odds = 2;
                    1: odds = 8;
                    default: odds = 32;
                endcase
                restart_odds = 64;
            end
            for (int k = 0; k < len; k++) begin
                w.start_req = (k == 0 && !noisy) || ($urandom_range(1, restart_odds) == 1);
                w.sensor_one = ($urandom_range(1, odds) != 1);
                w.sensor_two = ($urandom_range(1, odds) != 1);
                w.sensor_three = ($urandom_range(1, odds) != 1);
                send_word(w);
            end
        end
    endtask

    initial begin
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_FAST_PERIOD;
        i_cfg_data <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // An idle word and a start under the reset settings, then the whole sequence at
        // the shortest periods, with restarts in every phase.
        foreach (opening_words[k]) send_word(t_in_word'(opening_words[k]));
        write_settings(16'd1, 8'd1, 16'd1);
        foreach (directed_words[k]) send_word(t_in_word'(directed_words[k]));

        write_settings(16'd2, 8'd1, 16'd3);
        hold_req = 1'b1;
        random_runs(150);
        write_settings(16'd1, 8'd3, 16'd2);
        random_runs(150);
        write_settings(16'd3, 8'd2, 16'd1);
        random_runs(140);
        write_settings(16'd0, 8'd0, 16'd0);
        random_runs(120);
        write_settings(16'hFFFF, 8'hFF, 16'hFFFF);
        random_runs(40);
        write_settings(16'd1, 8'd40, 16'd2);
        random_runs(150);
        write_settings(16'($urandom_range(1, 6)), 8'($urandom_range(1, 4)),
                       16'($urandom_range(1, 8)));
        random_runs(150);
        write_settings(16'($urandom_range(1, 6)), 8'($urandom_range(1, 4)),
                       16'($urandom_range(1, 8)));
        quiet = 1'b1;
        random_runs(150);

        drain_results();
        $display("Drove %0d input words under %0d register settings; %0d result words checked.",
                 words_sent, settings_used, checked_words);
        $display("Result side held off once for %0d cycles while words kept coming.",
                 HOLD_CYCLES);
        if (failures == 0 && pending_words == 0) begin
            $display("Test completed successfully");
        end else begin
            if (pending_words != 0) $display("%0d expected words never arrived", pending_words);
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Timed out waiting for the block");
        $display("Test completed with failures");
        $finish;
    end

endmodule
